/* src/pnwm_pkg.sv */
package pnwm_pkg;

	localparam int VALUE_W   = 31;
	localparam int DIV_W     = 16;
	localparam int SQ_W      = 32;
	localparam int ACC_W     = 34;
	localparam int DIV_STEPS = 31;
	localparam int CNT_W     = 5;
	localparam int LEN_W     = 9;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_ADD1
	} alu_op_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_TEST,
		T_DIV,
		T_ADDQ,
		T_ADDD,
		T_NEXT,
		T_DONE
	} tst_state_t;

	typedef struct packed {
		logic valid;
		logic perfect;
	} test_res_t;

endpackage

/* src/pnwm_addsub.sv */
module pnwm_addsub (
	input  pnwm_pkg::alu_op_t                 op,
	input  logic [pnwm_pkg::ACC_W-1:0]        a,
	input  logic [pnwm_pkg::ACC_W-1:0]        b,
	output logic [pnwm_pkg::ACC_W-1:0]        sum
);

	logic [pnwm_pkg::ACC_W-1:0] b_mux;
	logic                       cin;

	always_comb begin
		unique case (op)
			pnwm_pkg::ALU_ADD: begin
				b_mux = b;
				cin   = 1'b0;
			end
			pnwm_pkg::ALU_SUB: begin
				b_mux = ~b;
				cin   = 1'b1;
			end
			pnwm_pkg::ALU_ADD1: begin
				b_mux = b;
				cin   = 1'b1;
			end
			default: begin
				b_mux = b;
				cin   = 1'b0;
			end
		endcase
	end

	assign sum = a + b_mux + pnwm_pkg::ACC_W'(cin);

endmodule

/* src/pnwm_tester.sv */
module pnwm_tester (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pnwm_pkg::VALUE_W-1:0]      value,
	input  logic                              ack,
	output logic                              idle,
	output pnwm_pkg::test_res_t               res
);

	pnwm_pkg::tst_state_t state_q, state_n;

	logic [pnwm_pkg::VALUE_W-1:0] n_q;
	logic [pnwm_pkg::DIV_W-1:0]   d_q;
	logic [pnwm_pkg::SQ_W-1:0]    sq_q;
	logic [pnwm_pkg::DIV_W-1:0]   rem_q;
	logic [pnwm_pkg::VALUE_W-1:0] quo_q;
	logic [pnwm_pkg::CNT_W-1:0]   cnt_q;
	logic [pnwm_pkg::ACC_W-1:0]   acc_q;
	logic                         perfect_q;

	pnwm_pkg::alu_op_t            alu_op;
	logic [pnwm_pkg::ACC_W-1:0]   alu_a;
	logic [pnwm_pkg::ACC_W-1:0]   alu_b;
	logic [pnwm_pkg::ACC_W-1:0]   alu_sum;
	logic                         alu_neg;
	logic                         divides;

	pnwm_addsub u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum)
	);

	assign alu_neg = alu_sum[pnwm_pkg::ACC_W-1];
	assign divides = (rem_q == '0);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			pnwm_pkg::T_IDLE: if (start) state_n = pnwm_pkg::T_TEST;
			pnwm_pkg::T_TEST: state_n = alu_neg ? pnwm_pkg::T_DONE : pnwm_pkg::T_DIV;
			pnwm_pkg::T_DIV: begin
				if (cnt_q == pnwm_pkg::CNT_W'(pnwm_pkg::DIV_STEPS - 1))
					state_n = pnwm_pkg::T_ADDQ;
			end
			pnwm_pkg::T_ADDQ: state_n = pnwm_pkg::T_ADDD;
			pnwm_pkg::T_ADDD: state_n = pnwm_pkg::T_NEXT;
			pnwm_pkg::T_NEXT: state_n = pnwm_pkg::T_TEST;
			pnwm_pkg::T_DONE: if (ack) state_n = pnwm_pkg::T_IDLE;
			default:          state_n = pnwm_pkg::T_IDLE;
		endcase
	end

	// shared adder operands and status
	always_comb begin
		alu_op      = pnwm_pkg::ALU_ADD;
		alu_a       = acc_q;
		alu_b       = '0;
		idle        = 1'b0;
		res.valid   = 1'b0;
		res.perfect = perfect_q;
		unique case (state_q)
			pnwm_pkg::T_IDLE: idle = 1'b1;
			pnwm_pkg::T_TEST: begin
				// borrow means d*d > n
				alu_op = pnwm_pkg::ALU_SUB;
				alu_a  = pnwm_pkg::ACC_W'(n_q);
				alu_b  = pnwm_pkg::ACC_W'(sq_q);
			end
			pnwm_pkg::T_DIV: begin
				alu_op = pnwm_pkg::ALU_SUB;
				alu_a  = pnwm_pkg::ACC_W'({rem_q, quo_q[pnwm_pkg::VALUE_W-1]});
				alu_b  = pnwm_pkg::ACC_W'(d_q);
			end
			pnwm_pkg::T_ADDQ: begin
				alu_a = acc_q;
				alu_b = pnwm_pkg::ACC_W'(quo_q);
			end
			pnwm_pkg::T_ADDD: begin
				alu_a = acc_q;
				alu_b = pnwm_pkg::ACC_W'(d_q);
			end
			pnwm_pkg::T_NEXT: begin
				// (d+1)^2 = d^2 + 2d + 1
				alu_op = pnwm_pkg::ALU_ADD1;
				alu_a  = pnwm_pkg::ACC_W'(sq_q);
				alu_b  = pnwm_pkg::ACC_W'({d_q, 1'b0});
			end
			pnwm_pkg::T_DONE: res.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pnwm_pkg::T_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pnwm_pkg::T_IDLE: begin
				if (start) begin
					n_q   <= value;
					d_q   <= pnwm_pkg::DIV_W'(2);
					sq_q  <= pnwm_pkg::SQ_W'(4);
					acc_q <= pnwm_pkg::ACC_W'(1);
				end
			end
			pnwm_pkg::T_TEST: begin
				rem_q <= '0;
				quo_q <= n_q;
				cnt_q <= '0;
				perfect_q <= (n_q[pnwm_pkg::VALUE_W-1:1] != '0) &&
					(acc_q == pnwm_pkg::ACC_W'(n_q));
			end
			pnwm_pkg::T_DIV: begin
				// one restoring quotient bit per cycle
				if (alu_neg)
					rem_q <= {rem_q[pnwm_pkg::DIV_W-2:0], quo_q[pnwm_pkg::VALUE_W-1]};
				else
					rem_q <= alu_sum[pnwm_pkg::DIV_W-1:0];
				quo_q <= {quo_q[pnwm_pkg::VALUE_W-2:0], ~alu_neg};
				cnt_q <= cnt_q + pnwm_pkg::CNT_W'(1);
			end
			pnwm_pkg::T_ADDQ: begin
				if (divides) acc_q <= alu_sum;
			end
			pnwm_pkg::T_ADDD: begin
				// square-root divisor counted once
				if (divides && (quo_q != pnwm_pkg::VALUE_W'(d_q))) acc_q <= alu_sum;
			end
			pnwm_pkg::T_NEXT: begin
				sq_q <= alu_sum[pnwm_pkg::SQ_W-1:0];
				d_q  <= d_q + pnwm_pkg::DIV_W'(1);
			end
			default: ;
		endcase
	end

endmodule

/* src/pnwm_window.sv */
module pnwm_window #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pnwm_pkg::LEN_W-1:0]       cfg_wdata,
	input  logic                             start,
	input  logic                             start_last,
	input  pnwm_pkg::test_res_t              res,
	output logic                             ack,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pnwm_pkg::LEN_W-1:0]       max_count,
	output logic                             window_short
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int LW = (CW > pnwm_pkg::LEN_W) ? CW : pnwm_pkg::LEN_W;

	logic                       ring [MAX_WINDOW];
	logic                       old_flag_q;

	logic [pnwm_pkg::LEN_W-1:0] window_len_q;
	logic [CW-1:0]              seq_len_q;
	logic [CW-1:0]              items_q;
	logic [CW-1:0]              wcount_q;
	logic [CW-1:0]              best_q;
	logic [AW-1:0]              wr_pos_q;
	logic                       last_q;
	logic                       evict_q;

	logic                       out_valid_q;
	logic [pnwm_pkg::LEN_W-1:0] max_count_q;
	logic                       window_short_q;

	logic [LW-1:0]              len_ext;
	logic [CW-1:0]              len_clamped;
	logic [CW-1:0]              k_cur;
	logic [AW-1:0]              old_addr;
	logic [AW-1:0]              wr_pos_inc;
	logic                       commit;
	logic [CW-1:0]              wc_drop;
	logic [CW-1:0]              wc_new;
	logic [CW-1:0]              items_new;
	logic [CW-1:0]              best_new;

	assign len_ext = LW'(window_len_q);

	always_comb begin
		priority if (window_len_q == '0)
			len_clamped = CW'(1);
		else if (len_ext > LW'(MAX_WINDOW))
			len_clamped = CW'(MAX_WINDOW);
		else
			len_clamped = CW'(len_ext);
	end

	// length is latched on the first word of a sequence
	assign k_cur = (items_q == '0) ? len_clamped : seq_len_q;

	// entry leaving the window: wr_pos - k modulo the ring size
	always_comb begin
		if ((CW + 1)'(wr_pos_q) >= (CW + 1)'(k_cur))
			old_addr = AW'((CW + 1)'(wr_pos_q) - (CW + 1)'(k_cur));
		else
			old_addr = AW'((CW + 1)'(wr_pos_q) + (CW + 1)'(MAX_WINDOW) - (CW + 1)'(k_cur));
	end

	assign wr_pos_inc = ((CW + 1)'(wr_pos_q) == (CW + 1)'(MAX_WINDOW - 1)) ?
		'0 : wr_pos_q + AW'(1);

	// a final word waits for the output register to free up
	assign ack    = !last_q || !out_valid_q || out_ready;
	assign commit = res.valid && ack;

	assign wc_drop   = (evict_q && old_flag_q && (wcount_q != '0)) ?
		wcount_q - CW'(1) : wcount_q;
	assign wc_new    = (res.perfect && (wc_drop < seq_len_q)) ? wc_drop + CW'(1) : wc_drop;
	assign items_new = ((CW + 1)'(items_q) < (CW + 1)'(MAX_WINDOW)) ?
		items_q + CW'(1) : items_q;
	assign best_new  = ((items_new >= seq_len_q) && (wc_new > best_q)) ? wc_new : best_q;

	always_ff @(posedge clk) begin
		if (start) old_flag_q <= ring[old_addr];
		if (commit) ring[wr_pos_q] <= res.perfect;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= pnwm_pkg::LEN_W'(1);
			seq_len_q    <= CW'(1);
			items_q      <= '0;
			wcount_q     <= '0;
			best_q       <= '0;
			wr_pos_q     <= '0;
			last_q       <= 1'b0;
			evict_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) window_len_q <= cfg_wdata;
			if (start) begin
				seq_len_q <= k_cur;
				last_q    <= start_last;
				evict_q   <= (items_q >= k_cur);
			end
			if (commit) begin
				if (last_q) begin
					items_q  <= '0;
					wcount_q <= '0;
					best_q   <= '0;
					wr_pos_q <= '0;
				end else begin
					items_q  <= items_new;
					wcount_q <= wc_new;
					best_q   <= best_new;
					wr_pos_q <= wr_pos_inc;
				end
			end
			if (commit && last_q)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && last_q) begin
			if (items_new < seq_len_q) begin
				max_count_q    <= '0;
				window_short_q <= 1'b1;
			end else begin
				max_count_q    <= pnwm_pkg::LEN_W'(best_new);
				window_short_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign max_count    = max_count_q;
	assign window_short = window_short_q;

endmodule

/* src/perfect_number_window_max.sv */
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     value[30:0], last
// out       output     out_valid / out_ready   max_count[8:0], window_short
// cfg       input      cfg_we, no wait         cfg_wdata[8:0] (window_len)
//
// a word with value n is tried against each divisor d from 2 while d*d <= n; in_ready stays
// low until its result has been committed to the window
// the one 34-bit adder does a single restoring quotient bit per cycle, 31 bits per trial divisor
// reset clears all control state; window_len comes up as 1, the flag ring is not cleared
// a final word whose result meets a full output register holds until out_ready
module perfect_number_window_max #(
	parameter int MAX_WINDOW = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pnwm_pkg::LEN_W-1:0]       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pnwm_pkg::VALUE_W-1:0]     value,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pnwm_pkg::LEN_W-1:0]       max_count,
	output logic                             window_short
);

	// word accepted into the divisor search
	logic                start;
	// tester result and window-side acknowledge
	pnwm_pkg::test_res_t res;
	logic                ack;
	logic                idle;

	assign in_ready = idle;
	assign start    = in_valid && idle;

	// trial-division sequencer around the shared adder
	pnwm_tester u_tester (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.ack    (ack),
		.idle   (idle),
		.res    (res)
	);

	// flag ring, running window count and the output register
	pnwm_window #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.start_last   (last),
		.res          (res),
		.ack          (ack),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.max_count    (max_count),
		.window_short (window_short)
	);

endmodule

/* src/pnwm_checker.sv */
module pnwm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [pnwm_pkg::LEN_W-1:0]       cfg_wdata,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [pnwm_pkg::VALUE_W-1:0]     value,
	input logic                             last,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [pnwm_pkg::LEN_W-1:0]       max_count,
	input logic                             window_short
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(max_count) && $stable(window_short))
		else $error("result word changed while stalled");

	// a short sequence never reports a count
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_short |-> max_count == '0)
		else $error("short sequence with nonzero count");

	// the divisor search keeps the input closed after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while search running");

	// a result only appears after the search has finished with the input closed
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a finished search");

endmodule

bind perfect_number_window_max pnwm_checker u_chk (.*);
